[src/comment_utf8_validator_defines.svh]
// Assertion macros shared by the comment validator RTL files.
`ifndef COMMENT_UTF8_VALIDATOR_DEFINES_SVH
`define COMMENT_UTF8_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define CUV_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("comment validator check failed");

// Checks that a condition implies a consequence in the same cycle.
`define CUV_ASSERT_IMPLY(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("comment validator implication failed");

`else

`define CUV_ASSERT(label, prop)
`define CUV_ASSERT_IMPLY(label, cond, cons)

`endif

`endif

[src/cuv_pkg.sv]
// Types, constants and byte classification functions for the comment validator.
`timescale 1ns / 1ps
`default_nettype none

package cuv_pkg;

   // Verdict codes carried on the result channel.
   typedef enum logic [2:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_NO_EQUALS  = 3'd1,
      VERDICT_BAD_NAME   = 3'd2,
      VERDICT_BAD_LENGTH = 3'd3,
      VERDICT_TRUNCATED  = 3'd4,
      VERDICT_BAD_SEQ    = 3'd5
   } verdict_type;

   // Scan phase of the comment in progress.
   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_VALUE = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   // One accepted input byte.
   typedef struct packed {
      logic       valid;
      logic [7:0] text_byte;
      logic       final_byte;
   } byte_type;

   // One verdict leaving the scanner.
   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } result_type;

   localparam logic [7:0] NAME_MIN    = 8'h20;
   localparam logic [7:0] NAME_MAX    = 8'h7D;
   localparam logic [7:0] EQUALS_CHAR = 8'h3D;
   localparam logic [7:0] NUL_CHAR    = 8'h00;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_MARK   = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hFE;
   localparam logic [7:0] LEAD2_LOW   = 8'hC0;
   localparam logic [7:0] LEAD3_LOW   = 8'hE0;
   localparam logic [7:0] LEAD3_SURR  = 8'hED;
   localparam logic [7:0] LEAD4_LOW   = 8'hF0;
   localparam logic [7:0] LEAD4_HIGH  = 8'hF4;
   localparam logic [7:0] CONT_MIN    = 8'h80;
   localparam logic [7:0] CONT_MAX    = 8'hBF;
   localparam logic [7:0] CONT_E0_MIN = 8'hA0;
   localparam logic [7:0] CONT_ED_MAX = 8'h9F;
   localparam logic [7:0] CONT_F0_MIN = 8'h90;
   localparam logic [7:0] CONT_F4_MAX = 8'h8F;

   // Character length from its lead byte; zero marks a bad length marker.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      begin
         if (!b[7])      len = 3'd1;
         else if (!b[6]) len = 3'd0;
         else if (!b[5]) len = 3'd2;
         else if (!b[4]) len = 3'd3;
         else if (!b[3]) len = 3'd4;
         else if (!b[2]) len = 3'd5;
         else if (!b[1]) len = 3'd6;
         else            len = 3'd0;
         return len;
      end
   endfunction

   // Checks one continuation byte against the lead; second marks the second byte.
   function automatic logic cont_ok(input logic [2:0] len, input logic [7:0] lead,
                                    input logic second, input logic [7:0] b);
      logic is_cont;
      logic ok;
      begin
         is_cont = (b & CONT_MASK) == CONT_MARK;
         ok = 1'b0;
         if (len == 3'd2) begin
            ok = is_cont && ((lead & LEAD2_MASK) != LEAD2_LOW);
         end else if (len == 3'd3) begin
            if (second && lead == LEAD3_LOW)       ok = (b >= CONT_E0_MIN) && (b <= CONT_MAX);
            else if (second && lead == LEAD3_SURR) ok = (b >= CONT_MIN) && (b <= CONT_ED_MAX);
            else                                   ok = is_cont;
         end else if (len == 3'd4) begin
            if (lead > LEAD4_HIGH)                 ok = 1'b0;
            else if (second && lead == LEAD4_LOW)  ok = (b >= CONT_F0_MIN) && (b <= CONT_MAX);
            else if (second && lead == LEAD4_HIGH) ok = (b >= CONT_MIN) && (b <= CONT_F4_MAX);
            else                                   ok = is_cont;
         end
         return ok;
      end
   endfunction

endpackage

`default_nettype wire

[src/cuv_scan.sv]
// Per-byte scanner: holds the comment state and decides the verdict on the last byte.
`timescale 1ns / 1ps
`default_nettype none
`include "comment_utf8_validator_defines.svh"

module cuv_scan
   import cuv_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire byte_type in_byte,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic        name_invalid_ff, name_invalid_in;
   logic [2:0]  seq_length_ff, seq_length_in;
   logic [2:0]  seq_remaining_ff, seq_remaining_in;
   logic [7:0]  lead_value_ff, lead_value_in;
   logic        seq_invalid_ff, seq_invalid_in;
   verdict_type first_error_ff, first_error_in;

   logic [7:0] b;
   logic [2:0] new_len;
   logic       second_byte;
   logic       cont_good;
   logic [2:0] remaining_dec;
   logic       seq_bad;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NAME;
         name_invalid_ff  <= 1'b0;
         seq_length_ff    <= 3'd0;
         seq_remaining_ff <= 3'd0;
         lead_value_ff    <= 8'h00;
         seq_invalid_ff   <= 1'b0;
         first_error_ff   <= VERDICT_OK;
      end else begin
         phase_ff         <= phase_in;
         name_invalid_ff  <= name_invalid_in;
         seq_length_ff    <= seq_length_in;
         seq_remaining_ff <= seq_remaining_in;
         lead_value_ff    <= lead_value_in;
         seq_invalid_ff   <= seq_invalid_in;
         first_error_ff   <= first_error_in;
      end
   end

   // Byte classification used by the value phase.
   assign b             = in_byte.text_byte;
   assign new_len       = lead_length(b);
   assign second_byte   = seq_remaining_ff == (seq_length_ff - 3'd1);
   assign cont_good     = cont_ok(seq_length_ff, lead_value_ff, second_byte, b);
   assign remaining_dec = seq_remaining_ff - 3'd1;
   assign seq_bad       = seq_invalid_ff | ~cont_good;

   // Next state and verdict.
   always_comb begin
      phase_in         = phase_ff;
      name_invalid_in  = name_invalid_ff;
      seq_length_in    = seq_length_ff;
      seq_remaining_in = seq_remaining_ff;
      lead_value_in    = lead_value_ff;
      seq_invalid_in   = seq_invalid_ff;
      first_error_in   = first_error_ff;
      result.valid     = 1'b0;
      result.verdict   = VERDICT_OK;

      if (in_byte.valid) begin
         unique case (phase_ff)
            PH_NAME: begin
               // A zero byte ends the name with no equals sign.
               if (b == NUL_CHAR) begin
                  first_error_in = VERDICT_NO_EQUALS;
                  phase_in       = PH_DONE;
               end else if (b == EQUALS_CHAR) begin
                  if (name_invalid_ff) begin
                     first_error_in = VERDICT_BAD_NAME;
                     phase_in       = PH_DONE;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end else if (b < NAME_MIN || b > NAME_MAX) begin
                  name_invalid_in = 1'b1;
               end
            end
            PH_VALUE: begin
               if (seq_remaining_ff == 3'd0) begin
                  // Lead byte of a new character.
                  if (new_len == 3'd0) begin
                     first_error_in = VERDICT_BAD_LENGTH;
                     phase_in       = PH_DONE;
                  end else if (new_len != 3'd1) begin
                     seq_length_in    = new_len;
                     seq_remaining_in = new_len - 3'd1;
                     lead_value_in    = b;
                     seq_invalid_in   = new_len >= 3'd5;
                  end
               end else begin
                  // Continuation byte; the verdict waits for the full character.
                  seq_invalid_in   = seq_bad;
                  seq_remaining_in = remaining_dec;
                  if (remaining_dec == 3'd0 && seq_bad) begin
                     first_error_in = VERDICT_BAD_SEQ;
                     phase_in       = PH_DONE;
                  end
               end
            end
            default: begin
            end
         endcase

         // The last byte yields the verdict and restarts the scanner.
         if (in_byte.final_byte) begin
            result.valid = 1'b1;
            if (phase_in == PH_DONE)            result.verdict = first_error_in;
            else if (phase_in == PH_NAME)       result.verdict = VERDICT_NO_EQUALS;
            else if (seq_remaining_in != 3'd0)  result.verdict = VERDICT_TRUNCATED;
            else                                result.verdict = VERDICT_OK;
            phase_in         = PH_NAME;
            name_invalid_in  = 1'b0;
            seq_length_in    = 3'd0;
            seq_remaining_in = 3'd0;
            lead_value_in    = 8'h00;
            seq_invalid_in   = 1'b0;
            first_error_in   = VERDICT_OK;
         end
      end
   end

   // A character in progress exists only in the value phase.
   `CUV_ASSERT_IMPLY(a_remaining_in_value, seq_remaining_ff != 3'd0, phase_ff == PH_VALUE)
   // Bytes still to come are fewer than the character length.
   `CUV_ASSERT_IMPLY(a_remaining_below_len, seq_remaining_ff != 3'd0,
                     seq_remaining_ff < seq_length_ff)
   // A recorded error and the decided phase always go together.
   `CUV_ASSERT(a_error_means_done, (phase_ff == PH_DONE) == (first_error_ff != VERDICT_OK))

endmodule

`default_nettype wire

[src/comment_utf8_validator.sv]
// Top level of the name=value comment validator with its result register.
//
//  Channel  Direction  Payload                            Marker
//  req_     in         tdata[7:0] text_byte               tlast = final_byte
//  rsp_     out        tdata[2:0] verdict, [7:3] zero     none
//
// A new byte can be accepted in every cycle while the result register is empty or being emptied.
// A verdict appears in the result register in the cycle after the last byte is accepted.
// The scanner state update is the single combinational step between transfers.
// Reset is synchronous and clears the scanner and the result valid flag, not the verdict data.
// A stalled result holds the input only while the result register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "comment_utf8_validator_defines.svh"

module comment_utf8_validator
   import cuv_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] text_byte
   input  wire        req_tlast,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] verdict, [7:3] zero
);

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   verdict_type verdict_ff;
   byte_type    in_byte;
   result_type  result;

   // Input transfer feeds the scanner directly.
   assign req_tready         = ~rsp_tvalid_ff | rsp_tready;
   assign in_byte.valid      = req_tvalid & req_tready;
   assign in_byte.text_byte  = req_tdata;
   assign in_byte.final_byte = req_tlast;

   cuv_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte),
      .result  (result)
   );

   // Result register: filled by a verdict, emptied by an output transfer.
   assign rsp_tvalid_in = result.valid | (rsp_tvalid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         verdict_ff <= result.verdict;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, verdict_ff};

   // A verdict never overwrites a result that is still waiting.
   `CUV_ASSERT_IMPLY(a_no_overwrite, result.valid, ~rsp_tvalid_ff | rsp_tready)
   // Valid results carry a defined verdict code.
   `CUV_ASSERT_IMPLY(a_verdict_range, rsp_tvalid_ff, verdict_ff <= VERDICT_BAD_SEQ)

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the name=value comment validator.
`timescale 1ns / 1ps

module tb_top;
   import cuv_pkg::*;

   localparam bit [7:0] NUL_BYTE      = 8'h00;
   localparam bit [7:0] EQUALS_BYTE   = 8'h3D;
   localparam bit [7:0] NAME_LOW      = 8'h20;
   localparam bit [7:0] NAME_HIGH     = 8'h7D;
   localparam bit [7:0] TAIL_LOW      = 8'h80;
   localparam bit [7:0] TAIL_HIGH     = 8'hBF;
   localparam bit [7:0] E0_LEAD       = 8'hE0;
   localparam bit [7:0] E0_TAIL_LOW   = 8'hA0;
   localparam bit [7:0] ED_LEAD       = 8'hED;
   localparam bit [7:0] ED_TAIL_HIGH  = 8'h9F;
   localparam bit [7:0] F0_LEAD       = 8'hF0;
   localparam bit [7:0] F0_TAIL_LOW   = 8'h90;
   localparam bit [7:0] F4_LEAD       = 8'hF4;
   localparam bit [7:0] F4_TAIL_HIGH  = 8'h8F;
   localparam int       LONG_HOLD     = 200;
   localparam int       RANDOM_BYTES  = 400;
   localparam int       MIN_COMMENTS  = 30;

   // Tracks the scan state of the comment in flight and the verdicts still owed.
   class verdict_tracker;
      phase_type   scan_phase;
      bit          name_bad;
      bit [2:0]    char_len;
      bit [2:0]    char_left;
      bit [7:0]    char_lead;
      bit          char_bad;
      verdict_type decided;
      verdict_type due_verdicts[$];
      int          mismatches;

      function new();
         mismatches = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         scan_phase = PH_NAME;
         name_bad   = 1'b0;
         char_len   = 3'd0;
         char_left  = 3'd0;
         char_lead  = 8'h00;
         char_bad   = 1'b0;
         decided    = VERDICT_OK;
      endfunction

      function void settle(verdict_type v);
         decided    = v;
         scan_phase = PH_DONE;
      endfunction

      // Character length from the lead byte; zero means the length marker is bad.
      function bit [2:0] char_length(bit [7:0] b);
         casez (b)
            8'b0???????: return 3'd1;
            8'b10??????: return 3'd0;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            8'b111110??: return 3'd5;
            8'b1111110?: return 3'd6;
            default:     return 3'd0;
         endcase
      endfunction

      // Range check of one trailing byte; the second byte carries the tighter limits.
      function bit follower_ok(bit [7:0] b);
         bit second;
         bit tail;
         second = (char_len - char_left) == 3'd1;
         tail   = b[7:6] == 2'b10;
         case (char_len)
            3'd2: return tail && (char_lead[7:1] != 7'b1100000);
            3'd3: begin
               if (second && char_lead == E0_LEAD) return b >= E0_TAIL_LOW && b <= TAIL_HIGH;
               if (second && char_lead == ED_LEAD) return b >= TAIL_LOW && b <= ED_TAIL_HIGH;
               return tail;
            end
            3'd4: begin
               if (char_lead > F4_LEAD) return 1'b0;
               if (second && char_lead == F0_LEAD) return b >= F0_TAIL_LOW && b <= TAIL_HIGH;
               if (second && char_lead == F4_LEAD) return b >= TAIL_LOW && b <= F4_TAIL_HIGH;
               return tail;
            end
            default: return 1'b0;
         endcase
      endfunction

      // Advances the scan by one accepted byte and owes a verdict on the last one.
      function void take_byte(bit [7:0] b, bit last);
         bit [2:0]    len;
         verdict_type v;
         case (scan_phase)
            PH_NAME: begin
               if (b == NUL_BYTE) begin
                  settle(VERDICT_NO_EQUALS);
               end else if (b == EQUALS_BYTE) begin
                  if (name_bad) settle(VERDICT_BAD_NAME);
                  else scan_phase = PH_VALUE;
               end else if (b < NAME_LOW || b > NAME_HIGH) begin
                  name_bad = 1'b1;
               end
            end
            PH_VALUE: begin
               if (char_left == 3'd0) begin
                  len = char_length(b);
                  if (len == 3'd0) begin
                     settle(VERDICT_BAD_LENGTH);
                  end else if (len > 3'd1) begin
                     char_len  = len;
                     char_left = len - 3'd1;
                     char_lead = b;
                     char_bad  = len >= 3'd5;
                  end
               end else begin
                  if (!follower_ok(b)) char_bad = 1'b1;
                  char_left = char_left - 3'd1;
                  if (char_left == 3'd0 && char_bad) settle(VERDICT_BAD_SEQ);
               end
            end
            default: ;
         endcase
         if (last) begin
            if (scan_phase == PH_DONE) v = decided;
            else if (scan_phase == PH_NAME) v = VERDICT_NO_EQUALS;
            else if (char_left != 3'd0) v = VERDICT_TRUNCATED;
            else v = VERDICT_OK;
            due_verdicts.push_back(v);
            clear_scan();
         end
      endfunction

      task report_mismatch(string what);
         $display("tb_top: mismatch at %0t ns: %s", $realtime, what);
         mismatches++;
      endtask

      // Compares one result transfer with the oldest owed verdict.
      task take_verdict(logic [7:0] data);
         verdict_type want;
         if (due_verdicts.size() == 0) begin
            report_mismatch($sformatf("tdata %02h arrived with no verdict owed", data));
         end else begin
            want = due_verdicts.pop_front();
            if (data !== {5'b00000, want})
               report_mismatch($sformatf("tdata %02h, expected verdict %0d", data, want));
         end
      endtask
   endclass

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] text_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [2:0] verdict, [7:3] zero

   verdict_tracker tracker = new();
   bit             stall_request = 1'b0;
   bit             steady_send   = 1'b0;
   int             bytes_sent    = 0;
   bit [7:0]       text_q[$];

   comment_utf8_validator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Result side: random back-pressure, calm stretches and one long hold.
   initial begin
      int  hold_left;
      int  calm_left;
      int  idle;
      bit  hold_done;
      hold_left = 0;
      calm_left = 0;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) tracker.take_verdict(rsp_tdata);
         if (stall_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_tready <= 1'b1;
         end else begin
            if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(20, 60);
            idle = idle_length();
            hold_left = (idle > 0) ? idle - 1 : 0;
            rsp_tready <= (idle == 0);
         end
      end
   end

   // Offers one byte after an optional gap and waits for its transfer.
   task automatic send_byte(bit [7:0] b, bit last);
      int idle;
      idle = steady_send ? 0 : idle_length();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_comment();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // Stops offering bytes and waits until every owed verdict has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.due_verdicts.size() != 0);
   endtask

   // Lead byte, then a second byte from the given range and plain trailing bytes.
   task automatic push_char(bit [7:0] lead, int follow, bit [7:0] lo2, bit [7:0] hi2);
      text_q.push_back(lead);
      if (follow > 0) text_q.push_back(8'($urandom_range(hi2, lo2)));
      for (int i = 1; i < follow; i++)
         text_q.push_back(8'($urandom_range(TAIL_HIGH, TAIL_LOW)));
   endtask

   // One value character: mostly well-formed, some at the range edges or broken.
   task automatic push_value_char();
      bit [7:0] odd_leads[0:10]  = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4,
                                     8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hFC};
      int       odd_follow[0:10] = '{1, 1, 2, 2, 3, 3, 3, 3, 3, 4, 5};
      bit [7:0] lead;
      int       pick;
      case ($urandom_range(0, 9))
         0, 1, 2: text_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
         3: text_q.push_back(8'($urandom_range(8'h7F, 8'h00)));
         4: push_char(8'($urandom_range(8'hDF, 8'hC2)), 1, TAIL_LOW, TAIL_HIGH);
         5: begin
            pick = $urandom_range(0, 2);
            lead = (pick == 0) ? E0_LEAD : (pick == 1) ? ED_LEAD :
                   8'($urandom_range(8'hEF, 8'hE1));
            if (lead == E0_LEAD) push_char(lead, 2, E0_TAIL_LOW, TAIL_HIGH);
            else if (lead == ED_LEAD) push_char(lead, 2, TAIL_LOW, ED_TAIL_HIGH);
            else push_char(lead, 2, TAIL_LOW, TAIL_HIGH);
         end
         6: begin
            pick = $urandom_range(0, 2);
            lead = (pick == 0) ? F0_LEAD : (pick == 1) ? F4_LEAD :
                   8'($urandom_range(8'hF3, 8'hF1));
            if (lead == F0_LEAD) push_char(lead, 3, F0_TAIL_LOW, TAIL_HIGH);
            else if (lead == F4_LEAD) push_char(lead, 3, TAIL_LOW, F4_TAIL_HIGH);
            else push_char(lead, 3, TAIL_LOW, TAIL_HIGH);
         end
         7: begin
            pick = $urandom_range(0, 10);
            push_char(odd_leads[pick], odd_follow[pick], 8'h60, 8'hCF);
         end
         8: push_char(8'($urandom_range(8'hFF, 8'h80)), $urandom_range(0, 5), 8'h00, 8'hFF);
         default: text_q.push_back(8'($urandom_range(8'hFF, 8'h00)));
      endcase
   endtask

   // A multi-byte character that the end of the comment cuts short.
   task automatic push_cut_char();
      bit [7:0] lead;
      int       full;
      case ($urandom_range(0, 4))
         0: begin lead = 8'($urandom_range(8'hDF, 8'hC2)); full = 1; end
         1: begin lead = 8'($urandom_range(8'hEF, 8'hE0)); full = 2; end
         2: begin lead = 8'($urandom_range(8'hF7, 8'hF0)); full = 3; end
         3: begin lead = 8'($urandom_range(8'hFB, 8'hF8)); full = 4; end
         default: begin lead = 8'($urandom_range(8'hFD, 8'hFC)); full = 5; end
      endcase
      push_char(lead, $urandom_range(0, full - 1), TAIL_LOW, TAIL_HIGH);
   endtask

   // Builds one random comment: name, equals sign, value, or plain noise.
   task automatic build_comment();
      text_q.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(8'hFF, 8'h00)));
      end else begin
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 9) == 0)
               text_q.push_back(8'($urandom_range(8'hFF, 8'h00)));
            else
               text_q.push_back(8'($urandom_range(NAME_HIGH, NAME_LOW)));
         end
         if ($urandom_range(0, 11) != 0) text_q.push_back(EQUALS_BYTE);
         repeat ($urandom_range(0, 6)) push_value_char();
         if ($urandom_range(0, 6) == 0) push_cut_char();
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(8'hFF, 8'h00)));
   endtask

   // Main sequence: directed comments, a forced stall, then random comments.
   initial begin
      int start_bytes;
      int comments;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Zero byte in the name, bad name byte, and a comment without an equals sign.
      text_q = '{8'h00};                     send_comment();
      text_q = '{8'h7F, 8'h3D};              send_comment();
      text_q = '{8'h41};                     send_comment();
      // Bad length markers, truncation, overlong form, complete five-byte form.
      text_q = '{8'h3D, 8'h80};              send_comment();
      text_q = '{8'h3D, 8'hFF};              send_comment();
      text_q = '{8'h3D, 8'hE2, 8'h82};       send_comment();
      text_q = '{8'h3D, 8'hC0, 8'hAF};       send_comment();
      text_q = '{8'h3D, 8'hF8, 8'h80, 8'h80, 8'h80, 8'h80};
      send_comment();
      // Name at both range edges and a valid four-byte character.
      text_q = '{8'h20, 8'h7D, 8'h3D, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_comment();
      wait_drained();

      // Hold the result side while single-byte comments keep coming.
      steady_send = 1'b1;
      stall_request <= 1'b1;
      repeat (12) begin
         text_q = '{8'h00};
         text_q[0] = 8'($urandom_range(8'h7E, 8'h20));
         send_comment();
      end
      steady_send = 1'b0;
      wait_drained();

      start_bytes = bytes_sent;
      comments = 0;
      while (bytes_sent - start_bytes < RANDOM_BYTES || comments < MIN_COMMENTS) begin
         if ($urandom_range(0, 7) == 0) steady_send = !steady_send;
         build_comment();
         send_comment();
         comments++;
      end
      wait_drained();
      repeat (8) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.due_verdicts.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/cuv_pkg.sv
src/cuv_scan.sv
src/comment_utf8_validator.sv
verif/tb_top.sv
